// ===== sv/epsc_pkg.sv =====
// Shared constants, types and tables for the epoch seconds to calendar converter
package epsc_pkg;

	localparam int SECONDS_WIDTH = 32;
	localparam int EPOCH_YEAR    = 1970;

	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int DAYS_PER_WEEK = 7;
	// the epoch day is a Thursday
	localparam int EPOCH_WEEKDAY = 4;

	localparam int DIVISOR_W = 17;
	localparam int DAYS_W    = SECONDS_WIDTH - 16;
	localparam int YEAR_W    = 12;
	localparam int DOY_W     = 9;
	localparam int MONTH_W   = 4;
	localparam int DOM_W     = 5;

	localparam int YEAR_DAYS     = 365;
	localparam int LEAP_DAYS     = 366;
	localparam int LAST_MONTH    = 11;

	localparam int EPOCH_MOD4   = EPOCH_YEAR % 4;
	localparam int EPOCH_MOD100 = EPOCH_YEAR % 100;
	localparam int EPOCH_MOD400 = EPOCH_YEAR % 400;

	// divisions the shared divider knows
	localparam int                  DIV_OP_W = 2;
	localparam logic [DIV_OP_W-1:0] DIV_DAY  = 2'd0;
	localparam logic [DIV_OP_W-1:0] DIV_HOUR = 2'd1;
	localparam logic [DIV_OP_W-1:0] DIV_MIN  = 2'd2;
	localparam logic [DIV_OP_W-1:0] DIV_WEEK = 2'd3;

	// Strip the power-of-two factor of each divisor, then multiply by the rounded-up
	// reciprocal of the odd factor. Each shift is the dividend's bit count after the
	// strip plus the bit count of the odd factor, which keeps the quotient exact.
	localparam int MUL_A_W = SECONDS_WIDTH - 7;
	localparam int RECIP_W = MUL_A_W + 2;
	localparam int PROD_W  = MUL_A_W + RECIP_W;

	// 86400 = 2^7 * 675, on the full seconds count
	localparam int              DAY_POW    = 7;
	localparam int              DAY_SHIFT  = MUL_A_W + 10;
	localparam longint unsigned DAY_RECIP  = ((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675;
	// 3600 = 2^4 * 225, on the time of day (under 2^17)
	localparam int              HOUR_POW   = 4;
	localparam int              HOUR_SHIFT = 13 + 8;
	localparam longint unsigned HOUR_RECIP = ((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225;
	// 60 = 2^2 * 15, on the rest of the hour (under 2^12)
	localparam int              MIN_POW    = 2;
	localparam int              MIN_SHIFT  = 10 + 4;
	localparam longint unsigned MIN_RECIP  = ((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15;
	// 7, on the day count plus four (under 2^DAYS_W)
	localparam int              WEEK_SHIFT = DAYS_W + 3;
	localparam longint unsigned WEEK_RECIP = ((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7;

	typedef struct packed {
		logic                     start;
		logic [SECONDS_WIDTH-1:0] dividend;
		logic [DIV_OP_W-1:0]      op;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic [SECONDS_WIDTH-1:0] quotient;
		logic [DIVISOR_W-1:0]     remainder;
	} div_rsp_t;

	typedef struct packed {
		logic               done;
		logic [YEAR_W-1:0]  year;
		logic [DOY_W-1:0]   day_of_year;
		logic [MONTH_W-1:0] month;
		logic [DOM_W-1:0]   day_of_month;
	} cal_rsp_t;

	function automatic logic [DOM_W-1:0] month_len(input logic leap, input logic [MONTH_W-1:0] mon);
		logic [DOM_W-1:0] len;
		unique case (mon)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== sv/epsc_in_if.sv =====
// Input channel: one epoch seconds word
interface epsc_in_if;
	logic                              valid;
	logic                              ready;
	logic [epsc_pkg::SECONDS_WIDTH-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== sv/epsc_out_if.sv =====
// Output channel: one calendar date and time of day word
interface epsc_out_if;
	logic                        valid;
	logic                        ready;
	logic [5:0]                  second;
	logic [5:0]                  minute;
	logic [4:0]                  hour;
	logic [2:0]                  weekday;
	logic [epsc_pkg::YEAR_W-1:0]  year;
	logic [epsc_pkg::DOY_W-1:0]   day_of_year;
	logic [epsc_pkg::MONTH_W-1:0] month;
	logic [epsc_pkg::DOM_W-1:0]   day_of_month;

	modport source (output valid, output second, output minute, output hour, output weekday,
		output year, output day_of_year, output month, output day_of_month, input ready);
	modport sink   (input valid, input second, input minute, input hour, input weekday,
		input year, input day_of_year, input month, input day_of_month, output ready);
endinterface

// ===== sv/epoch_seconds_to_calendar.sv =====
// Top level: epoch seconds to UTC calendar date and time of day
//
//   port   dir   word carried
//   din    sink  epoch_seconds (32 bits, seconds since 1970-01-01 UTC)
//   dout   src   second, minute, hour, weekday, year, day_of_year, month, day_of_month
//
// Operation: four runs of the shared reciprocal divider (seconds by 86400, rest by 3600,
// rest by 60, days plus four by 7), then the calendar stepper takes off whole years and
// then whole months; din is ready again once the finished word has moved to the output
// register.
// Reset clears the sequencer and the valid flags only; there is no clearing pass.
// din is ready whenever the sequencer is idle, even while a result waits on dout;
// a finished word holds in the sequencer until the output register is free.
module epoch_seconds_to_calendar (
	input logic         clk,
	input logic         arst_n,
	epsc_in_if.sink     din,
	epsc_out_if.source  dout
);
	import epsc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DAY  = 3'd1;
	localparam logic [2:0] S_HOUR = 3'd2;
	localparam logic [2:0] S_MIN  = 3'd3;
	localparam logic [2:0] S_WDAY = 3'd4;
	localparam logic [2:0] S_CAL  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	cal_rsp_t cal_rsp;
	logic     cal_start;

	logic [DAYS_W-1:0] days_q;
	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [5:0]        second_q;
	logic [2:0]        weekday_q;

	logic              out_valid_q;
	logic [5:0]        out_second_q;
	logic [5:0]        out_minute_q;
	logic [4:0]        out_hour_q;
	logic [2:0]        out_weekday_q;
	logic [YEAR_W-1:0] out_year_q;
	logic [DOY_W-1:0]  out_doy_q;
	logic [MONTH_W-1:0] out_month_q;
	logic [DOM_W-1:0]  out_dom_q;

	logic accept;
	logic out_free;

	assign din.ready = (state_q == S_IDLE);
	assign accept    = din.valid && din.ready;
	assign out_free  = !out_valid_q || dout.ready;

	// pick the next division as soon as the last one reports done
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = din.epoch_seconds;
		div_req.op       = DIV_DAY;
		cal_start        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				div_req.start = accept;
			end
			S_DAY: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = SECONDS_WIDTH'(div_rsp.remainder);
				div_req.op       = DIV_HOUR;
			end
			S_HOUR: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = SECONDS_WIDTH'(div_rsp.remainder);
				div_req.op       = DIV_MIN;
			end
			S_MIN: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = SECONDS_WIDTH'(days_q) + SECONDS_WIDTH'(EPOCH_WEEKDAY);
				div_req.op       = DIV_WEEK;
			end
			S_WDAY: begin
				cal_start = div_rsp.done;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept)         state_q <= S_DAY;
				S_DAY:  if (div_rsp.done)   state_q <= S_HOUR;
				S_HOUR: if (div_rsp.done)   state_q <= S_MIN;
				S_MIN:  if (div_rsp.done)   state_q <= S_WDAY;
				S_WDAY: if (div_rsp.done)   state_q <= S_CAL;
				S_CAL:  if (cal_rsp.done)   state_q <= S_DONE;
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_rsp.done) begin
			unique case (state_q)
				S_DAY:  days_q    <= div_rsp.quotient[DAYS_W-1:0];
				S_HOUR: hour_q    <= div_rsp.quotient[4:0];
				S_MIN: begin
					minute_q <= div_rsp.quotient[5:0];
					second_q <= div_rsp.remainder[5:0];
				end
				S_WDAY: weekday_q <= div_rsp.remainder[2:0];
				default: begin
				end
			endcase
		end
		if (state_q == S_DONE && out_free) begin
			out_second_q  <= second_q;
			out_minute_q  <= minute_q;
			out_hour_q    <= hour_q;
			out_weekday_q <= weekday_q;
			out_year_q    <= cal_rsp.year;
			out_doy_q     <= cal_rsp.day_of_year;
			out_month_q   <= cal_rsp.month;
			out_dom_q     <= cal_rsp.day_of_month;
		end
	end

	epsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	epsc_cal u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cal_start),
		.days   (days_q),
		.rsp    (cal_rsp)
	);

	assign dout.valid        = out_valid_q;
	assign dout.second       = out_second_q;
	assign dout.minute       = out_minute_q;
	assign dout.hour         = out_hour_q;
	assign dout.weekday      = out_weekday_q;
	assign dout.year         = out_year_q;
	assign dout.day_of_year  = out_doy_q;
	assign dout.month        = out_month_q;
	assign dout.day_of_month = out_dom_q;

endmodule

// ===== sv/epsc_div.sv =====
// Shared divider for the fixed divisors: reciprocal multiply, then multiply back for the remainder
module epsc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  epsc_pkg::div_req_t req,
	output epsc_pkg::div_rsp_t rsp
);
	import epsc_pkg::*;

	logic [SECONDS_WIDTH-1:0] num_q;
	logic [DIV_OP_W-1:0]      op_q;
	logic [PROD_W-1:0]        prod_q;
	logic [SECONDS_WIDTH-1:0] quo_q;
	logic [SECONDS_WIDTH-1:0] back_q;
	logic [DIVISOR_W-1:0]     rem_q;
	logic [3:0]               step_q;
	logic                     done_q;

	logic [MUL_A_W-1:0]       mul_a;
	logic [RECIP_W-1:0]       recip;
	logic [SECONDS_WIDTH-1:0] quo;
	logic [DIVISOR_W-1:0]     divisor;

	always_comb begin
		unique case (op_q)
			DIV_DAY: begin
				mul_a   = MUL_A_W'(num_q >> DAY_POW);
				recip   = RECIP_W'(DAY_RECIP);
				quo     = SECONDS_WIDTH'(prod_q >> DAY_SHIFT);
				divisor = DIVISOR_W'(SECS_PER_DAY);
			end
			DIV_HOUR: begin
				mul_a   = MUL_A_W'(num_q >> HOUR_POW);
				recip   = RECIP_W'(HOUR_RECIP);
				quo     = SECONDS_WIDTH'(prod_q >> HOUR_SHIFT);
				divisor = DIVISOR_W'(SECS_PER_HOUR);
			end
			DIV_MIN: begin
				mul_a   = MUL_A_W'(num_q >> MIN_POW);
				recip   = RECIP_W'(MIN_RECIP);
				quo     = SECONDS_WIDTH'(prod_q >> MIN_SHIFT);
				divisor = DIVISOR_W'(SECS_PER_MIN);
			end
			DIV_WEEK: begin
				mul_a   = MUL_A_W'(num_q);
				recip   = RECIP_W'(WEEK_RECIP);
				quo     = SECONDS_WIDTH'(prod_q >> WEEK_SHIFT);
				divisor = DIVISOR_W'(DAYS_PER_WEEK);
			end
		endcase
	end

	// advance one step a cycle: product, quotient, multiply back, remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			step_q <= {step_q[2:0], req.start};
			done_q <= step_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			op_q  <= req.op;
		end
		if (step_q[0]) begin
			prod_q <= mul_a * recip;
		end
		if (step_q[1]) begin
			quo_q <= quo;
		end
		if (step_q[2]) begin
			back_q <= quo_q * SECONDS_WIDTH'(divisor);
		end
		if (step_q[3]) begin
			rem_q <= DIVISOR_W'(num_q - back_q);
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== sv/epsc_cal.sv =====
// Calendar stepper: takes whole years, then whole months, off a day count
module epsc_cal (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [epsc_pkg::DAYS_W-1:0] days,
	output epsc_pkg::cal_rsp_t          rsp
);
	import epsc_pkg::*;

	logic [DAYS_W-1:0]  days_q;
	logic [YEAR_W-1:0]  year_q;
	logic [1:0]         mod4_q;
	logic [6:0]         mod100_q;
	logic [8:0]         mod400_q;
	logic [MONTH_W-1:0] mon_q;
	logic [DOY_W-1:0]   doy_q;
	logic [DOM_W-1:0]   dom_q;
	logic               year_busy_q;
	logic               mon_busy_q;
	logic               done_q;

	logic              leap;
	logic [DOY_W-1:0]  ylen;
	logic [DOM_W-1:0]  mlen;
	logic              year_fits;
	logic              mon_more;

	assign leap      = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
	assign ylen      = leap ? DOY_W'(LEAP_DAYS) : DOY_W'(YEAR_DAYS);
	assign mlen      = month_len(leap, mon_q);
	assign year_fits = days_q < DAYS_W'(ylen);
	assign mon_more  = (mon_q < MONTH_W'(LAST_MONTH)) && (days_q >= DAYS_W'(mlen));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_busy_q <= 1'b0;
			mon_busy_q  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				year_busy_q <= 1'b1;
			end else if (year_busy_q && year_fits) begin
				year_busy_q <= 1'b0;
				mon_busy_q  <= 1'b1;
			end else if (mon_busy_q && !mon_more) begin
				mon_busy_q <= 1'b0;
				done_q     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			days_q   <= days;
			year_q   <= YEAR_W'(EPOCH_YEAR);
			mod4_q   <= 2'(EPOCH_MOD4);
			mod100_q <= 7'(EPOCH_MOD100);
			mod400_q <= 9'(EPOCH_MOD400);
			mon_q    <= '0;
		end else if (year_busy_q) begin
			if (year_fits) begin
				doy_q <= days_q[DOY_W-1:0];
			end else begin
				days_q   <= days_q - DAYS_W'(ylen);
				year_q   <= year_q + 1'b1;
				mod4_q   <= mod4_q + 1'b1;
				mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 1'b1;
				mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 1'b1;
			end
		end else if (mon_busy_q) begin
			if (mon_more) begin
				days_q <= days_q - DAYS_W'(mlen);
				mon_q  <= mon_q + 1'b1;
			end else begin
				dom_q <= days_q[DOM_W-1:0] + 1'b1;
			end
		end
	end

	assign rsp.done         = done_q;
	assign rsp.year         = year_q;
	assign rsp.day_of_year  = doy_q;
	assign rsp.month        = mon_q;
	assign rsp.day_of_month = dom_q;

endmodule

// ===== sv/epsc_chk.sv =====
// Port checker for the epoch seconds to calendar converter, with its bind
module epsc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        din_valid,
	input logic                        din_ready,
	input logic                        dout_valid,
	input logic                        dout_ready,
	input logic [5:0]                  second,
	input logic [5:0]                  minute,
	input logic [4:0]                  hour,
	input logic [2:0]                  weekday,
	input logic [epsc_pkg::YEAR_W-1:0]  year,
	input logic [epsc_pkg::DOY_W-1:0]   day_of_year,
	input logic [epsc_pkg::MONTH_W-1:0] month,
	input logic [epsc_pkg::DOM_W-1:0]   day_of_month
);
	import epsc_pkg::*;

	// second, minute, hour, weekday and month of a shown word lie in their calendar ranges, and day of month is not zero
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24)
			&& (weekday < 3'd7) && (month <= MONTH_W'(LAST_MONTH))
			&& (day_of_month != '0))
		else $error("calendar field out of range");

	// day of month can never run ahead of day of year
	a_dom_doy: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid |-> ({4'd0, day_of_month} <= day_of_year + 1'b1))
		else $error("day of month exceeds day of year");

	// the converter works on one word at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(din_valid && din_ready) |=> !din_ready)
		else $error("input taken while a conversion is running");

	// a stalled result stays valid, and its year, day of year and second hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dout_valid && !dout_ready) |=> dout_valid && $stable(year)
			&& $stable(day_of_year) && $stable(second))
		else $error("stalled result changed");

endmodule

bind epoch_seconds_to_calendar epsc_chk u_epsc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.din_valid    (din.valid),
	.din_ready    (din.ready),
	.dout_valid   (dout.valid),
	.dout_ready   (dout.ready),
	.second       (dout.second),
	.minute       (dout.minute),
	.hour         (dout.hour),
	.weekday      (dout.weekday),
	.year         (dout.year),
	.day_of_year  (dout.day_of_year),
	.month        (dout.month),
	.day_of_month (dout.day_of_month)
);
